>>> src/keypad_servo_position_controller_macros.svh
// assertion helpers shared by the controller rtl
`ifndef KEYPAD_SERVO_POSITION_CONTROLLER_MACROS_SVH
`define KEYPAD_SERVO_POSITION_CONTROLLER_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define KSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define KSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kspc_pkg.sv
package kspc_pkg;

  localparam logic [3:0] KeyDigitMin = 4'd1;
  localparam logic [3:0] KeyDigitMax = 4'd9;
  localparam logic [3:0] KeyStar     = 4'd10;
  localparam logic [3:0] KeyZero     = 4'd11;
  localparam logic [3:0] KeyHash     = 4'd12;

  localparam int unsigned TableTop  = 180;
  localparam int unsigned RomDepth  = TableTop + 1;
  localparam int unsigned SegOneTop = 60;
  localparam int unsigned SegTwoTop = 99;
  localparam int unsigned MaxDigits = 3;

  typedef logic [9:0] ref_rom_t [RomDepth];

  typedef struct packed {
    logic       motor_direction;
    logic [9:0] pwm_duty;
    logic [7:0] angle_now;
    logic [7:0] entry_now;
    logic [1:0] digits_now;
    logic [9:0] reference_now;
  } result_t;

  // angle to pot reference, coefficients scaled by 1e4, rounded half up
  function automatic ref_rom_t build_ref_rom();
    ref_rom_t rom;
    longint   x;
    longint   s;
    for (int a = 0; a < int'(RomDepth); a++) begin
      x = longint'(a);
      if (a <= int'(SegOneTop)) begin
        s = 68858 * x + 515150;
      end else if (a <= int'(SegTwoTop)) begin
        s = 19 * x * x * x - 4852 * x * x + 412240 * x - 6814900;
      end else begin
        s = -372 * x * x + 164190 * x - 7558600;
      end
      if (s < 0) begin
        s = 0;
      end
      s = (s + 5000) / 10000;
      if (s > 1023) begin
        s = 1023;
      end
      rom[a] = 10'(s);
    end
    return rom;
  endfunction

endpackage

>>> src/keypad_servo_position_controller.sv
// keypad servo position controller
// input channel (in_valid_i/in_ready_o) carries one item per transfer: either a
// keypad code (action_i = 0, key_code_i) or a new pot sample (action_i = 1,
// pot_sample_i). digits build an entry of up to three digits, star reloads the
// entry from the committed angle, hash commits the entry and looks up the pot
// reference in a 181-entry rom.
// output channel (out_valid_o/out_ready_i) returns exactly one result per item:
// drive direction and pwm duty from the latest sample against the reference,
// plus the committed angle, entry, digit count and reference after the item.
// each result is registered, in the skid buffer if the output is stalled.
// throughput: one item per cycle while in_ready_o is high; the state update and
// rom lookup sit in one stage between the input and the output register.
// the output register is backed by a one-entry skid buffer, so one more item
// is taken while the receiver stalls; in_ready_o drops only when both are full.
// reset: entry, digits, angle and sample clear, the reference loads the value
// for angle zero, and both output entries are empty.
`include "keypad_servo_position_controller_macros.svh"

module keypad_servo_position_controller #(
  parameter int unsigned MAX_ANGLE = 180
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [3:0] key_code_i,
  input  logic [9:0] pot_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       motor_direction_o,
  output logic [9:0] pwm_duty_o,
  output logic [7:0] angle_now_o,
  output logic [7:0] entry_now_o,
  output logic [1:0] digits_now_o,
  output logic [9:0] reference_now_o
);

  localparam kspc_pkg::ref_rom_t RefRom = kspc_pkg::build_ref_rom();

  logic [7:0] entry_q, entry_d;
  logic [1:0] count_q, count_d;
  logic [7:0] angle_q, angle_d;
  logic [9:0] ref_q, ref_d;
  logic [9:0] sample_q, sample_d;

  logic              out_vld_q;
  logic              skid_vld_q;
  kspc_pkg::result_t out_q;
  kspc_pkg::result_t skid_q;
  kspc_pkg::result_t res_d;

  logic        accept;
  logic [3:0]  digit;
  logic        is_digit;
  logic [11:0] digit_val;
  logic        digit_ovf;
  logic [9:0]  diff;

  assign in_ready_o = ~skid_vld_q;
  assign accept     = in_valid_i & in_ready_o;

  // digit value of the key, zero key maps to 0
  always_comb begin
    digit    = 4'd0;
    is_digit = 1'b0;
    case (key_code_i) inside
      kspc_pkg::KeyZero: begin
        is_digit = 1'b1;
      end
      [kspc_pkg::KeyDigitMin:kspc_pkg::KeyDigitMax]: begin
        digit    = key_code_i;
        is_digit = 1'b1;
      end
      default: ;
    endcase
  end

  assign digit_val = (count_q == 2'd0) ? {8'd0, digit}
                                       : 12'(entry_q) * 12'd10 + 12'(digit);
  assign digit_ovf = (digit_val > 12'(MAX_ANGLE)) ||
                     (count_q == 2'(kspc_pkg::MaxDigits));

  always_comb begin
    entry_d  = entry_q;
    count_d  = count_q;
    angle_d  = angle_q;
    ref_d    = ref_q;
    sample_d = sample_q;
    if (action_i) begin
      sample_d = pot_sample_i;
    end else if (key_code_i == kspc_pkg::KeyStar) begin
      entry_d = angle_q;
      count_d = 2'd0;
    end else if (key_code_i == kspc_pkg::KeyHash) begin
      // committing the same angle leaves the digit count alone
      if (angle_q != entry_q) begin
        angle_d = entry_q;
        count_d = 2'd0;
        if (entry_q <= 8'(kspc_pkg::TableTop)) begin
          ref_d = RefRom[entry_q];
        end
      end
    end else if (is_digit) begin
      if (digit_ovf) begin
        entry_d = angle_q;
        count_d = 2'd0;
      end else begin
        entry_d = digit_val[7:0];
        count_d = count_q + 2'd1;
      end
    end
  end

  // below the reference the duty wraps: 1023 - (ref - sample)
  assign diff = sample_d - ref_d;

  always_comb begin
    res_d.motor_direction = (sample_d < ref_d);
    res_d.pwm_duty        = res_d.motor_direction ? (diff - 10'd1) : diff;
    res_d.angle_now       = angle_d;
    res_d.entry_now       = entry_d;
    res_d.digits_now      = count_d;
    res_d.reference_now   = ref_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= 8'd0;
      count_q  <= 2'd0;
      angle_q  <= 8'd0;
      ref_q    <= RefRom[0];
      sample_q <= 10'd0;
    end else if (accept) begin
      entry_q  <= entry_d;
      count_q  <= count_d;
      angle_q  <= angle_d;
      ref_q    <= ref_d;
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign motor_direction_o = out_q.motor_direction;
  assign pwm_duty_o        = out_q.pwm_duty;
  assign angle_now_o       = out_q.angle_now;
  assign entry_now_o       = out_q.entry_now;
  assign digits_now_o      = out_q.digits_now;
  assign reference_now_o   = out_q.reference_now;

  `KSPC_ASSERT(a_skid_behind_out, !skid_vld_q || out_vld_q, "skid entry without output entry")
  `KSPC_ASSERT(a_entry_in_range, (entry_q <= 8'(MAX_ANGLE)) && (angle_q <= 8'(MAX_ANGLE)), "entry or angle above limit")
  `KSPC_ASSERT(a_ref_tracks_angle, (angle_q > 8'(kspc_pkg::TableTop)) || (ref_q == RefRom[angle_q]), "reference does not match committed angle")
  `KSPC_ASSERT_NEXT(a_full_blocks_input, skid_vld_q && out_vld_q && !out_ready_i, skid_vld_q && !in_ready_o, "input taken while both entries full")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned AngleLimit = 180;
  localparam int unsigned RandomItems = 440;
  localparam int unsigned IdlePercent = 27;
  localparam int unsigned DrainCycles = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       action_i = 1'b0;
  logic [3:0] key_code_i = '0;
  logic [9:0] pot_sample_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       motor_direction_o;
  logic [9:0] pwm_duty_o;
  logic [7:0] angle_now_o;
  logic [7:0] entry_now_o;
  logic [1:0] digits_now_o;
  logic [9:0] reference_now_o;

  // own copy of the controller state
  logic [7:0] m_entry;
  logic [1:0] m_digits;
  logic [7:0] m_angle;
  logic [9:0] m_ref;
  logic [9:0] m_sample;

  kspc_pkg::result_t expected_results[$];
  bit                no_idle = 1'b0;
  int unsigned       error_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       commits_seen = 0;
  int unsigned       results_checked = 0;

  keypad_servo_position_controller #(
    .MAX_ANGLE(AngleLimit)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .key_code_i,
    .pot_sample_i,
    .out_valid_o,
    .out_ready_i,
    .motor_direction_o,
    .pwm_duty_o,
    .angle_now_o,
    .entry_now_o,
    .digits_now_o,
    .reference_now_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
  end

  // pot target for a committed angle, three polynomial segments scaled by 1e4
  function automatic logic [9:0] angle_to_target(int unsigned a);
    longint x;
    longint s;
    x = longint'(a);
    if (a <= 60) begin
      s = 68858 * x + 515150;
    end else if (a < 100) begin
      s = 19 * x * x * x - 4852 * x * x + 412240 * x - 6814900;
    end else begin
      s = -372 * x * x + 164190 * x - 7558600;
    end
    if (s < 0) begin
      s = 0;
    end
    s = (s + 5000) / 10000;
    if (s > 1023) begin
      s = 1023;
    end
    return 10'(s);
  endfunction

  function automatic void servo_reset();
    m_entry  = '0;
    m_digits = '0;
    m_angle  = '0;
    m_ref    = angle_to_target(0);
    m_sample = '0;
  endfunction

  function automatic kspc_pkg::result_t servo_step(logic act, logic [3:0] key,
                                                   logic [9:0] smp);
    kspc_pkg::result_t res;
    int unsigned       digit;
    int unsigned       val;
    int unsigned       cnt;
    bit                is_digit;
    is_digit = 1'b0;
    digit = 0;
    if (act) begin
      m_sample = smp;
    end else if (key == kspc_pkg::KeyStar) begin
      m_entry  = m_angle;
      m_digits = '0;
    end else if (key == kspc_pkg::KeyHash) begin
      // equal entry leaves everything alone, digit count included
      if (m_angle != m_entry) begin
        m_angle  = m_entry;
        m_digits = '0;
        if (m_angle <= kspc_pkg::TableTop) begin
          m_ref = angle_to_target(m_angle);
        end
      end
    end else if (key == kspc_pkg::KeyZero) begin
      is_digit = 1'b1;
    end else if (key >= kspc_pkg::KeyDigitMin && key <= kspc_pkg::KeyDigitMax) begin
      is_digit = 1'b1;
      digit = key;
    end
    if (is_digit) begin
      if (m_digits == 0) begin
        val = digit;
        cnt = 1;
      end else begin
        val = int'(m_entry) * 10 + digit;
        cnt = int'(m_digits) + 1;
      end
      if (val > AngleLimit || cnt > kspc_pkg::MaxDigits) begin
        m_entry  = m_angle;
        m_digits = '0;
      end else begin
        m_entry  = 8'(val);
        m_digits = 2'(cnt);
      end
    end
    if (m_sample >= m_ref) begin
      res.motor_direction = 1'b0;
      res.pwm_duty = m_sample - m_ref;
    end else begin
      res.motor_direction = 1'b1;
      res.pwm_duty = 10'd1023 - (m_ref - m_sample);
    end
    res.angle_now     = m_angle;
    res.entry_now     = m_entry;
    res.digits_now    = m_digits;
    res.reference_now = m_ref;
    return res;
  endfunction

  // entered right after a rising edge; leaves valid high after the transfer
  task automatic send_item(logic act, logic [3:0] key, logic [9:0] smp);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_code_i   <= key;
    pot_sample_i <= smp;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    expected_results.push_back(servo_step(act, key, smp));
    items_sent++;
    if (!act && key == kspc_pkg::KeyHash) begin
      commits_seen++;
    end
  endtask

  task automatic send_key(logic [3:0] key);
    send_item(1'b0, key, 10'($urandom));
  endtask

  task automatic send_sample(logic [9:0] smp);
    send_item(1'b1, 4'($urandom), smp);
  endtask

  task automatic send_digit(int unsigned d);
    send_key(d == 0 ? kspc_pkg::KeyZero : 4'(d));
  endtask

  // decimal digits of an angle, optionally with leading zeros
  task automatic type_angle(int unsigned a, bit pad);
    if (pad || a >= 100) begin
      send_digit(a / 100);
    end
    if (pad || a >= 10) begin
      send_digit((a / 10) % 10);
    end
    send_digit(a % 10);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    kspc_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (motor_direction_o !== want.motor_direction) begin
          $error("motor_direction: expected %0d, actual %0d",
                 want.motor_direction, motor_direction_o);
          error_count++;
        end
        if (pwm_duty_o !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, pwm_duty_o);
          error_count++;
        end
        if (angle_now_o !== want.angle_now) begin
          $error("angle_now: expected %0d, actual %0d", want.angle_now, angle_now_o);
          error_count++;
        end
        if (entry_now_o !== want.entry_now) begin
          $error("entry_now: expected %0d, actual %0d", want.entry_now, entry_now_o);
          error_count++;
        end
        if (digits_now_o !== want.digits_now) begin
          $error("digits_now: expected %0d, actual %0d", want.digits_now, digits_now_o);
          error_count++;
        end
        if (reference_now_o !== want.reference_now) begin
          $error("reference_now: expected %0d, actual %0d",
                 want.reference_now, reference_now_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_values();
    send_sample(10'd0);
    send_sample(10'd1023);
  endtask

  task automatic test_key_decoding();
    send_key(4'd0);
    send_key(4'd13);
    send_key(4'd14);
    send_key(4'd15);
    // key code is don't-care on a sample
    send_item(1'b1, kspc_pkg::KeyHash, 10'h2aa);
    send_item(1'b1, 4'd15, 10'h155);
  endtask

  task automatic test_entry_edges();
    type_angle(180, 1'b0);
    send_key(kspc_pkg::KeyHash);
    type_angle(9, 1'b0);
    send_key(kspc_pkg::KeyHash);
    // entry equal to the committed angle: hash keeps the digit count
    send_digit(9);
    send_key(kspc_pkg::KeyHash);
    // too large a value
    type_angle(18, 1'b0);
    send_digit(1);
    // fourth digit
    type_angle(0, 1'b1);
    send_digit(0);
    send_digit(5);
    send_key(kspc_pkg::KeyStar);
  endtask

  task automatic test_duty_edges();
    send_sample(m_ref);
    send_sample(m_ref - 10'd1);
  endtask

  task automatic random_sequence();
    int unsigned a;
    int unsigned n;
    a = $urandom_range(0, 180);
    if ($urandom_range(0, 9) == 0) begin
      a = ($urandom_range(0, 1) != 0) ? 180 : 0;
    end
    type_angle(a, $urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0: send_key(kspc_pkg::KeyStar);
      1: send_digit($urandom_range(0, 9));
      2: send_key(4'($urandom_range(13, 15)));
      default: ;
    endcase
    send_key(kspc_pkg::KeyHash);
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        send_sample(m_ref + 10'($urandom_range(0, 4)) - 10'd2);
      end else begin
        send_sample(10'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 99) < 80) begin
        random_sequence();
      end else begin
        send_item(1'($urandom), 4'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) begin
      random_sequence();
    end
    no_idle = 1'b0;
    // sender holds off until the output side is empty
    wait_drained();
    random_sequence();
  endtask

  initial begin
    int unsigned spin;
    servo_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_key_decoding();
    test_entry_edges();
    test_duty_edges();
    test_back_to_back();
    test_random_traffic();
    in_valid_i <= 1'b0;
    spin = 0;
    while (expected_results.size() != 0 && spin < DrainCycles) begin
      @(posedge clk_i);
      spin++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    repeat (8) @(posedge clk_i);
    $display("sent %0d items (keys, samples, noise), %0d hash commits, %0d results checked",
             items_sent, commits_seen, results_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
